FILE: design/spq4_pkg.sv
// Shared types and constants for the four-level strict priority queue.
// Depends on nothing; every other file but spq4_store imports it.
package spq4_pkg;

    // Fixed widths of the word fields on both channels.
    localparam int OP_W    = 1;
    localparam int VALUE_W = 32;
    localparam int LEVEL_W = 2;
    localparam int COUNT_W = 7;

    // Operation codes carried in the op field.
    localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OP_W-1:0] OP_SERVE  = 1'b1;

    // Control sequencer states.
    typedef enum logic
    {
        S_IDLE,
        S_READ
    } state_t;

endpackage

FILE: design/spq4_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on spq4_pkg for the field widths.
interface spq4_req_if;
    import spq4_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value_in;
    logic [LEVEL_W-1:0] level_in;

    modport source (output valid, output op, output value_in, output level_in, input ready);
    modport sink   (input valid, input op, input value_in, input level_in, output ready);
endinterface

interface spq4_rsp_if;
    import spq4_pkg::*;

    logic               valid;
    logic               ready;
    logic               ok;
    logic [VALUE_W-1:0] value_out;
    logic [LEVEL_W-1:0] level_out;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output ok, output value_out, output level_out,
                    output count, input ready);
    modport sink   (input valid, input ok, input value_out, input level_out,
                    input count, output ready);
endinterface

FILE: design/spq4_store.sv
// Entry store: single-port synchronous RAM with a registered read word.
// Depends on nothing but the clock; the queue controller drives it.
module spq4_store #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/strict_priority_queue_four_levels.sv
// Four-level strict priority queue: top level with the pointer and count
// bookkeeping and the result register. Depends on spq4_pkg, spq4_if, spq4_store.
//
// Each request word either inserts a data word at an urgency level (0 is the
// most urgent) or serves the oldest entry of the most urgent non-empty level.
// Every request gives exactly one response word carrying ok, the served data
// word and level (zero unless a serve succeeded) and the number of entries
// held after the operation. An insert is refused when CAPACITY entries are
// held or the level is not below LEVELS; a serve of an empty queue fails.
// A request passes through the accept cycle and then the read state. In the
// accept cycle the head, tail and count registers are updated and the single
// port of the entry RAM is written (insert) or read (serve); in the read state
// the registered RAM word is loaded into the response register. No request is
// taken in the read state, and a new one is taken in the same cycle as the
// previous response leaves. The entry RAM needs no clearing after reset: a
// serve only reads slots written by earlier inserts.
module strict_priority_queue_four_levels #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32,
    parameter int LEVELS      = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    spq4_req_if.sink  req,
    spq4_rsp_if.source rsp
);
    import spq4_pkg::*;

    localparam int PW     = $clog2(CAPACITY);
    localparam int LW     = $clog2(LEVELS);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int ADDR_W = LW + PW;

    // Per-level ring pointers and entry counts, plus the overall count.
    logic [PW-1:0] head_reg  [LEVELS];
    logic [PW-1:0] head_next [LEVELS];
    logic [PW-1:0] tail_reg  [LEVELS];
    logic [PW-1:0] tail_next [LEVELS];
    logic [CW-1:0] cnt_reg   [LEVELS];
    logic [CW-1:0] cnt_next  [LEVELS];
    logic [CW-1:0] total_reg;
    logic [CW-1:0] total_next;

    state_t state_reg;
    state_t state_next;

    // Outcome of the accepted request, held while the RAM read completes.
    logic          pend_ok_reg;
    logic          pend_ok_next;
    logic          pend_srv_reg;
    logic          pend_srv_next;
    logic [LW-1:0] pend_lvl_reg;
    logic [LW-1:0] pend_lvl_next;
    logic [CW-1:0] pend_cnt_reg;
    logic [CW-1:0] pend_cnt_next;

    // Response register.
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic               rsp_ok_reg;
    logic [VALUE_W-1:0] rsp_value_reg;
    logic [LEVEL_W-1:0] rsp_level_reg;
    logic [COUNT_W-1:0] rsp_count_reg;

    logic          accept;
    logic          is_insert;
    logic          lvl_valid;
    logic          ins_ok;
    logic          srv_ok;
    logic [LW-1:0] ins_lvl;
    logic [LW-1:0] srv_lvl;
    logic          srv_found;

    logic                   mem_we;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_addr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [VALUE_WIDTH-1:0] mem_rdata;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        ring_next = (p == PW'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    // Priority encoder: the lowest non-empty level wins.
    always_comb
    begin
        srv_found = 1'b0;
        srv_lvl   = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (cnt_reg[i] != '0)
            begin
                srv_found = 1'b1;
                srv_lvl   = LW'(i);
            end
        end
    end

    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign is_insert = (req.op == OP_INSERT);
    assign lvl_valid = (32'(req.level_in) < LEVELS);
    assign ins_lvl   = LW'(req.level_in);
    assign ins_ok    = is_insert && lvl_valid && (total_reg < CW'(CAPACITY));
    assign srv_ok    = !is_insert && srv_found;

    // Bookkeeping update and RAM access in the accept cycle.
    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        cnt_next      = cnt_reg;
        total_next    = total_reg;
        pend_ok_next  = pend_ok_reg;
        pend_srv_next = pend_srv_reg;
        pend_lvl_next = pend_lvl_reg;
        pend_cnt_next = pend_cnt_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_addr      = is_insert ? {ins_lvl, tail_reg[ins_lvl]} : {srv_lvl, head_reg[srv_lvl]};
        mem_wdata     = VALUE_WIDTH'(req.value_in);

        if (accept)
        begin
            if (ins_ok)
            begin
                tail_next[ins_lvl] = ring_next(tail_reg[ins_lvl]);
                cnt_next[ins_lvl]  = cnt_reg[ins_lvl] + 1'b1;
                total_next         = total_reg + 1'b1;
                mem_we             = 1'b1;
            end
            else if (srv_ok)
            begin
                head_next[srv_lvl] = ring_next(head_reg[srv_lvl]);
                cnt_next[srv_lvl]  = cnt_reg[srv_lvl] - 1'b1;
                total_next         = total_reg - 1'b1;
                mem_re             = 1'b1;
            end
            pend_ok_next  = ins_ok || srv_ok;
            pend_srv_next = srv_ok;
            pend_lvl_next = srv_ok ? srv_lvl : '0;
            pend_cnt_next = total_next;
        end
    end

    // Sequencer: idle until a request is taken, then the read state, which loads the response.
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next     = S_IDLE;
                rsp_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            total_reg     <= '0;
            pend_ok_reg   <= 1'b0;
            pend_srv_reg  <= 1'b0;
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            total_reg     <= total_next;
            pend_ok_reg   <= pend_ok_next;
            pend_srv_reg  <= pend_srv_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_lvl_reg <= pend_lvl_next;
        pend_cnt_reg <= pend_cnt_next;
        if (state_reg == S_READ)
        begin
            rsp_ok_reg    <= pend_ok_reg;
            rsp_value_reg <= pend_srv_reg ? VALUE_W'(mem_rdata) : '0;
            rsp_level_reg <= LEVEL_W'(pend_lvl_reg);
            rsp_count_reg <= COUNT_W'(pend_cnt_reg);
        end
    end

    // No request is taken in the read state, so RAM accesses never come back to
    // back and a read never overlaps the write of the same slot.
    spq4_store #(
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.ok        = rsp_ok_reg;
    assign rsp.value_out = rsp_value_reg;
    assign rsp.level_out = rsp_level_reg;
    assign rsp.count     = rsp_count_reg;

`ifndef SYNTH
    // The queue never holds more than its capacity.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // No second request is taken while one is in flight.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("request taken during RAM read");

    // The read cycle always ends with a response on the output.
    a_read_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> rsp.valid)
        else $error("response missing after read cycle");

    // Serving an empty queue must fail.
    a_empty_serve: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.op == OP_SERVE && total_reg == '0) |=> !pend_ok_reg)
        else $error("serve of empty queue reported success");
`endif

endmodule

FILE: sim/spq4_queue_checker.sv
// Response checker for the four-level strict priority queue.
// Watches both channel interfaces, keeps its own copy of the queue state and compares
// every response word with the one predicted for the oldest request. Depends on spq4_pkg, spq4_if.
`timescale 1ns / 1ps

module spq4_queue_checker #(
    parameter int CAPACITY = 64,
    parameter int LEVELS   = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    spq4_req_if         req,
    spq4_rsp_if         rsp,
    output int unsigned mismatch_count,
    output int unsigned words_in_flight
);
    import spq4_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] value;
        logic [LEVEL_W-1:0] level;
        logic [COUNT_W-1:0] count;
    } reply_t;

    // Mirror of the queue: one ring of CAPACITY slots per urgency level.
    logic [VALUE_W-1:0] slot_word [LEVELS][CAPACITY];
    int unsigned        head_slot  [LEVELS];
    int unsigned        tail_slot  [LEVELS];
    int unsigned        level_fill [LEVELS];
    int unsigned        total_fill;

    reply_t             replies_due [$];
    int unsigned        fail_tally;

    function automatic int unsigned ring_advance(int unsigned p);
        return (p == CAPACITY - 1) ? 0 : p + 1;
    endfunction

    // Applies one request word to the mirror and returns the response it must produce.
    function automatic reply_t queue_op(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                        logic [LEVEL_W-1:0] level);
        reply_t reply;
        bit     served;
        int     lv;
        reply  = '0;
        served = 1'b0;
        if (op == OP_INSERT)
        begin
            if (level < LEVELS && total_fill < CAPACITY)
            begin
                slot_word[level][tail_slot[level]] = value;
                tail_slot[level]  = ring_advance(tail_slot[level]);
                level_fill[level] = level_fill[level] + 1;
                total_fill        = total_fill + 1;
                reply.ok          = 1'b1;
            end
        end
        else
        begin
            for (lv = 0; lv < LEVELS; lv++)
            begin
                if (!served && level_fill[lv] != 0)
                begin
                    reply.value    = slot_word[lv][head_slot[lv]];
                    reply.level    = LEVEL_W'(lv);
                    reply.ok       = 1'b1;
                    head_slot[lv]  = ring_advance(head_slot[lv]);
                    level_fill[lv] = level_fill[lv] - 1;
                    total_fill     = total_fill - 1;
                    served         = 1'b1;
                end
            end
        end
        reply.count = COUNT_W'(total_fill);
        return reply;
    endfunction

    task automatic compare_field(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            fail_tally++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            for (int lv = 0; lv < LEVELS; lv++)
            begin
                head_slot[lv]  = 0;
                tail_slot[lv]  = 0;
                level_fill[lv] = 0;
            end
            total_fill = 0;
            fail_tally = 0;
            replies_due.delete();
            mismatch_count  <= 0;
            words_in_flight <= 0;
        end
        else
        begin
            // A response leaving at this edge belongs to an earlier request, which is
            // already queued, so pushing first keeps the order intact.
            if (req.valid && req.ready)
                replies_due.push_back(queue_op(req.op, req.value_in, req.level_in));
            if (rsp.valid && rsp.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t ns: response word with no request waiting, expected none, actual %0h",
                             $time, {rsp.ok, rsp.value_out, rsp.level_out, rsp.count});
                    fail_tally++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    compare_field("ok", VALUE_W'(want.ok), VALUE_W'(rsp.ok));
                    compare_field("value_out", want.value, rsp.value_out);
                    compare_field("level_out", VALUE_W'(want.level), VALUE_W'(rsp.level_out));
                    compare_field("count", VALUE_W'(want.count), VALUE_W'(rsp.count));
                end
            end
            mismatch_count  <= fail_tally;
            words_in_flight <= replies_due.size();
        end
    end

endmodule

FILE: sim/tb_strict_priority_queue_four_levels.sv
// Testbench top for the four-level strict priority queue: clock, reset, request and
// response traffic, watchdog and verdict. Depends on spq4_pkg, spq4_if, the block and
// spq4_queue_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module tb_strict_priority_queue_four_levels;
    import spq4_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int LEVELS         = 4;
    localparam int RANDOM_WORDS   = 600;
    // Long receiver hold-off; far longer than one request takes, so the block stalls its input.
    localparam int RX_HOLD_CYCLES = 200;
    // Cycles left to run once nothing is in flight.
    localparam int TAIL_CYCLES    = 8;
    // Cycles without any accepted word before the run is declared hung. The longest
    // legitimate quiet stretch is the receiver hold-off above.
    localparam int STALL_LIMIT    = 4000;

    // Shapes of the random traffic. A fill phase pushes the queue to capacity and past it,
    // a drain phase mostly serves, may empty it and serve past empty, a mixed phase interleaves both.
    typedef enum { PH_FILL, PH_DRAIN, PH_MIX } phase_kind_t;

    logic        clk;
    logic        rst_n;
    int unsigned mismatch_count;
    int unsigned words_in_flight;
    int unsigned hold_marker  = 0;
    int unsigned quiet_cycles = 0;

    spq4_req_if req_ch ();
    spq4_rsp_if rsp_ch ();

    strict_priority_queue_four_levels #(
        .CAPACITY   (CAPACITY),
        .VALUE_WIDTH(VALUE_W),
        .LEVELS     (LEVELS)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    spq4_queue_checker #(
        .CAPACITY(CAPACITY),
        .LEVELS  (LEVELS)
    ) queue_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .words_in_flight(words_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Idle length between words: mostly none, often short, now and then a long gap.
    function automatic int idle_gap(bit enabled);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offers one word and returns once it is taken and its idle gap is over. Valid stays high
    // when the next word follows at once, so it is never dropped and raised in one step.
    task automatic send_word(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                             logic [LEVEL_W-1:0] level, int gap);
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.value_in <= value;
        req_ch.level_in <= level;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops offering and waits until every predicted response word has been taken.
    // The checker updates its count at the clock edge, so the first edge is always waited.
    task automatic wait_all_replies();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (words_in_flight != 0);
    endtask

    // Request side: reset, a directed sequence, then phases of random traffic.
    initial
    begin : stimulus
        int unsigned        random_sent;
        int                 phase_no;
        int                 n;
        int                 insert_pct;
        bit                 idle_on;
        bit                 one_level;
        phase_kind_t        kind;
        logic [OP_W-1:0]    op;
        logic [LEVEL_W-1:0] fill_level;
        logic [LEVEL_W-1:0] lvl;

        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.op       <= OP_INSERT;
        req_ch.value_in <= '0;
        req_ch.level_in <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Serving the empty queue must fail with zero data and level.
        send_word(OP_SERVE, '0, 2'd0, idle_gap(1'b1));
        // Extremes of the data word at the least urgent level, then one entry per level,
        // two of them at the most urgent one.
        send_word(OP_INSERT, 32'hFFFF_FFFF, 2'd3, idle_gap(1'b1));
        send_word(OP_INSERT, 32'h0000_0000, 2'd3, idle_gap(1'b1));
        send_word(OP_INSERT, 32'hA5A5_A5A5, 2'd2, idle_gap(1'b1));
        send_word(OP_INSERT, 32'h5A5A_5A5A, 2'd1, idle_gap(1'b1));
        send_word(OP_INSERT, 32'h8000_0001, 2'd0, idle_gap(1'b1));
        send_word(OP_INSERT, 32'h7FFF_FFFE, 2'd0, idle_gap(1'b1));
        send_word(OP_SERVE, '0, 2'd0, idle_gap(1'b1));
        // A late urgent entry must still overtake the older, less urgent ones.
        send_word(OP_INSERT, 32'h1234_5678, 2'd0, idle_gap(1'b1));
        // Serve everything in strict order, then once more on the empty queue; the data
        // and level fields of a serve carry junk that must be ignored.
        repeat (7) send_word(OP_SERVE, 32'hDEAD_BEEF, 2'd3, idle_gap(1'b1));
        // Removing the last entry and inserting again afterwards.
        send_word(OP_INSERT, 32'h0000_0001, 2'd2, idle_gap(1'b1));
        send_word(OP_SERVE, '0, 2'd1, idle_gap(1'b1));
        send_word(OP_INSERT, 32'h0000_0002, 2'd2, idle_gap(1'b1));
        send_word(OP_SERVE, '0, 2'd0, idle_gap(1'b1));

        // The first phase fills the queue past capacity and the second mostly serves to drain it;
        // after that the phase kinds are random.
        random_sent = 0;
        phase_no    = 0;
        while (random_sent < RANDOM_WORDS)
        begin
            if (phase_no == 0)
                kind = PH_FILL;
            else if (phase_no == 1)
                kind = PH_DRAIN;
            else
                kind = phase_kind_t'($urandom_range(0, 2));
            idle_on = ($urandom_range(0, 3) != 0);
            // Once, the receiver holds off for a long stretch while requests keep coming
            // back to back, so the block holds its response and refuses further words.
            if (phase_no == 2)
            begin
                hold_marker <= hold_marker + 1;
                idle_on = 1'b0;
            end
            fill_level = LEVEL_W'($urandom_range(0, 3));
            one_level  = 1'($urandom_range(0, 1));
            insert_pct = $urandom_range(35, 70);
            case (kind)
                PH_FILL:  n = CAPACITY + $urandom_range(2, 8);
                PH_DRAIN: n = $urandom_range(40, 75);
                default:  n = $urandom_range(20, 60);
            endcase

            repeat (n)
            begin
                case (kind)
                    PH_FILL:  op = OP_INSERT;
                    PH_DRAIN: op = ($urandom_range(0, 9) == 0) ? OP_INSERT : OP_SERVE;
                    default:  op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_SERVE;
                endcase
                // A fill phase sometimes stacks every entry on one level, which wraps that
                // level's ring and checks that a single level can take the whole capacity.
                if (kind == PH_FILL && one_level)
                    lvl = fill_level;
                else
                    lvl = LEVEL_W'($urandom_range(0, 3));
                send_word(op, $urandom, lvl, idle_gap(idle_on));
                random_sent++;
            end

            // The sender pauses until the block has answered everything, at least once.
            if (phase_no == 0 || $urandom_range(0, 2) == 0)
                wait_all_replies();
            phase_no++;
        end

        wait_all_replies();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Response side: stretches of steady acceptance alternate with stretches of random
    // stalls, and the long hold-off is counted here when the request side asks for it.
    initial
    begin : receiver
        int unsigned hold_seen;
        int          stall_left;
        int          stretch_left;
        bit          rx_idle_on;

        hold_seen    = 0;
        stall_left   = 0;
        stretch_left = 0;
        rx_idle_on   = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_marker != hold_seen)
            begin
                hold_seen = hold_marker;
                rsp_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    rx_idle_on   = ($urandom_range(0, 2) != 0);
                    stretch_left = $urandom_range(40, 250);
                end
                stretch_left--;
                if (stall_left == 0 && rx_idle_on && $urandom_range(0, 3) == 0)
                    stall_left = idle_gap(1'b1);
                if (stall_left > 0)
                begin
                    stall_left--;
                    rsp_ch.ready <= 1'b0;
                end
                else
                    rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake on either channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
